// ===== design/wodr_pkg.sv =====
// ----------------------------------------------------------------------------
// wodr_pkg
// shared types and constants of the wheel odometry core
// ----------------------------------------------------------------------------
package wodr_pkg;

    localparam int SPEED_BITS   = 12;
    localparam int HEAD_BITS    = 16;
    localparam int POS_BITS     = 28;
    localparam int GAIN_BITS    = 16;
    localparam int CFG_IDX_BITS = 8;
    localparam int CORDIC_ITERS = 16;

    localparam logic [7:0] CFG_LEFT_GAIN  = 8'd0;
    localparam logic [7:0] CFG_RIGHT_GAIN = 8'd1;

    localparam logic [15:0] LEFT_GAIN_RST  = 16'd21352;
    localparam logic [15:0] RIGHT_GAIN_RST = 16'd20998;

    localparam logic signed [23:0] HEAD_K       = 24'sd2360910;
    localparam logic signed [19:0] PI_Q13       = 20'sd25736;
    localparam logic signed [19:0] TWO_PI_Q13   = 20'sd51472;
    localparam logic signed [19:0] HALF_PI_Q16  = 20'sd102944;
    localparam logic signed [19:0] PI_Q16       = 20'sd205887;
    localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [29:0] POS_MAX      = 30'sd134217727;
    localparam logic signed [29:0] POS_MIN      = -30'sd134217728;

    typedef logic [19:0] t_atan_tab [CORDIC_ITERS];
    localparam t_atan_tab ATAN_Q16 = '{
        20'd51472, 20'd30385, 20'd16055, 20'd8150, 20'd4091, 20'd2047,
        20'd1024, 20'd512, 20'd256, 20'd128, 20'd64, 20'd32, 20'd16,
        20'd8, 20'd4, 20'd2
    };

    // cordic control between sequencer and rotator
    typedef struct packed {
        logic                        start;
        logic signed [HEAD_BITS-1:0] angle;
    } t_cordic_req;

    typedef struct packed {
        logic               done;
        logic signed [33:0] cos_v;
        logic signed [33:0] sin_v;
    } t_cordic_rsp;

endpackage

// ===== design/wodr_if.sv =====
// ----------------------------------------------------------------------------
// wodr_if
// valid/ready channel interfaces of the core
// ----------------------------------------------------------------------------
interface wodr_tick_if #(parameter int TICK_BITS = 12);
    logic                 valid;
    logic                 ready;
    logic [TICK_BITS-1:0] left_ticks;
    logic [TICK_BITS-1:0] right_ticks;
    modport source (output valid, left_ticks, right_ticks, input ready);
    modport sink (input valid, left_ticks, right_ticks, output ready);
endinterface

interface wodr_pose_if;
    logic        valid;
    logic        ready;
    logic [11:0] left_speed;
    logic [11:0] right_speed;
    logic        pose_updated;
    logic signed [15:0] heading;
    logic signed [27:0] pos_x;
    logic signed [27:0] pos_y;
    modport source (output valid, left_speed, right_speed, pose_updated, heading,
                    pos_x, pos_y, input ready);
    modport sink (input valid, left_speed, right_speed, pose_updated, heading,
                  pos_x, pos_y, output ready);
endinterface

interface wodr_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/wheel_odometry_dead_reckoning_core.sv =====
// ----------------------------------------------------------------------------
// wheel_odometry_dead_reckoning_core
// encoder speed filter and dead-reckoning pose integrator
// ----------------------------------------------------------------------------
// a plain sample runs the ring sum and speed multiplies; one that closes a
//   pose group adds group sum, averages, heading, the 16 cordic iterations
//   and position update. Requests are taken only in idle; the output
//   register lets the next request start while a result waits
// reset: synchronous active low; rings, groups, slots and pose cleared,
//   gains take their reset values
module wheel_odometry_dead_reckoning_core
    import wodr_pkg::*;
#(
    parameter int AVG_TAPS   = 3,
    parameter int POSE_GROUP = 5,
    parameter int TICK_BITS  = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wodr_tick_if.sink   i_tick,
    wodr_pose_if.source o_pose,
    wodr_cfg_if.sink    i_cfg
);

    localparam int RS_BITS = (AVG_TAPS < 2) ? 1 : $clog2(AVG_TAPS);
    localparam int GS_BITS = $clog2(POSE_GROUP + 1);
    localparam int GI_BITS = (POSE_GROUP < 2) ? 1 : $clog2(POSE_GROUP);
    localparam int CNT_BITS = ((RS_BITS > GI_BITS) ? RS_BITS : GI_BITS) + 1;
    localparam int SUM_BITS = TICK_BITS + 5;
    localparam int GSUM_BITS = SPEED_BITS + 5;
    // reciprocal of the group size, exact floor for any group sum
    localparam int AVG_SH = GSUM_BITS + GI_BITS;
    localparam int AVG_RECIP = (2**AVG_SH + POSE_GROUP - 1) / POSE_GROUP;

    typedef enum logic [3:0] {
        S_IDLE, S_SUM, S_MULL, S_MULR, S_GSUM, S_AVGL, S_AVGR, S_HEAD, S_WRAP,
        S_CORD, S_PX, S_PY, S_OUT
    } t_state;

    t_state r_state;
    logic [15:0] r_lgain, r_rgain;
    logic [TICK_BITS-1:0] r_lring [AVG_TAPS];
    logic [TICK_BITS-1:0] r_rring [AVG_TAPS];
    logic [SPEED_BITS-1:0] r_lgrp [POSE_GROUP];
    logic [SPEED_BITS-1:0] r_rgrp [POSE_GROUP];
    logic [RS_BITS-1:0] r_rslot;
    logic [GS_BITS-1:0] r_gslot;
    logic [CNT_BITS-1:0] r_cnt;
    logic [SUM_BITS-1:0]  r_lsum, r_rsum;
    logic [GSUM_BITS-1:0] r_glsum, r_grsum;
    logic [SPEED_BITS-1:0] r_vl, r_vr;
    logic signed [HEAD_BITS-1:0] r_head;
    logic signed [19:0] r_h;
    logic signed [POS_BITS-1:0] r_px, r_py;
    logic r_upd, r_ovalid, r_cstart;

    // output register
    logic [SPEED_BITS-1:0] r_ovl, r_ovr;
    logic r_oupd;
    logic signed [HEAD_BITS-1:0] r_ohead;
    logic signed [POS_BITS-1:0] r_opx, r_opy;
    logic out_free;

    // shared multiplier, one product per cycle
    logic signed [33:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [55:0] mul_p;
    assign mul_p = 56'(mul_a) * 56'(mul_b);

    t_cordic_req cq;
    t_cordic_rsp cr;
    assign cq.start = r_cstart;
    assign cq.angle = r_head;

    wodr_cordic u_cordic (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(cq), .o_rsp(cr));

    logic [SPEED_BITS-1:0] r_al, r_ar;
    logic signed [20:0] trip_len;
    logic signed [29:0] pos_new;
    logic signed [POS_BITS-1:0] pos_old;
    logic [SUM_BITS+15:0] spd;

    // distance of the group in signed Q16.5
    assign trip_len = (21'(r_ar) + 21'(r_al)) * 21'sd32;

    // operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MULL: begin mul_a = 34'(r_lsum); mul_b = 21'(r_lgain); end
            S_MULR: begin mul_a = 34'(r_rsum); mul_b = 21'(r_rgain); end
            S_AVGL: begin mul_a = 34'(r_glsum); mul_b = 21'(AVG_RECIP); end
            S_AVGR: begin mul_a = 34'(r_grsum); mul_b = 21'(AVG_RECIP); end
            S_HEAD: begin mul_a = 34'(HEAD_K); mul_b = 21'(r_ar) - 21'(r_al); end
            S_PX:   begin mul_a = cr.cos_v; mul_b = trip_len; end
            S_PY:   begin mul_a = cr.sin_v; mul_b = trip_len; end
            default: ;
        endcase
    end

    assign spd = mul_p[SUM_BITS+15:0];
    assign pos_old = (r_state == S_PX) ? r_px : r_py;
    assign pos_new = 30'(pos_old) + 30'((mul_p + (56'sd1 <<< 29)) >>> 30);

    logic [SPEED_BITS-1:0] spd_sat;
    assign spd_sat = (spd[SUM_BITS+15:16] > (SUM_BITS)'(4095)) ? 12'd4095
                   : spd[27:16];

    logic signed [POS_BITS-1:0] pos_sat;
    assign pos_sat = (pos_new > POS_MAX) ? POS_BITS'(POS_MAX)
                   : (pos_new < POS_MIN) ? POS_BITS'(POS_MIN) : pos_new[POS_BITS-1:0];

    logic signed [19:0] h_add;
    assign h_add = 20'((mul_p + 56'sd32768) >>> 16);

    assign out_free     = !r_ovalid || o_pose.ready;
    assign i_tick.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lgain <= LEFT_GAIN_RST;
            r_rgain <= RIGHT_GAIN_RST;
            for (int i = 0; i < AVG_TAPS; i++) begin
                r_lring[i] <= '0;
                r_rring[i] <= '0;
            end
            for (int i = 0; i < POSE_GROUP; i++) begin
                r_lgrp[i] <= '0;
                r_rgrp[i] <= '0;
            end
            r_rslot  <= '0;
            r_gslot  <= '0;
            r_head   <= '0;
            r_px     <= '0;
            r_py     <= '0;
            r_ovalid <= 1'b0;
            r_cstart <= 1'b0;
            r_upd    <= 1'b0;
            r_ovl    <= '0;
            r_ovr    <= '0;
            r_oupd   <= 1'b0;
            r_ohead  <= '0;
            r_opx    <= '0;
            r_opy    <= '0;
        end else begin
            r_cstart <= (r_state == S_WRAP);
            if (i_cfg.valid) begin
                if (i_cfg.index == CFG_LEFT_GAIN) r_lgain <= i_cfg.data;
                else if (i_cfg.index == CFG_RIGHT_GAIN) r_rgain <= i_cfg.data;
            end
            // output register, loaded once the result slot is free
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
                r_ovl    <= r_vl;
                r_ovr    <= r_vr;
                r_oupd   <= r_upd;
                r_ohead  <= r_head;
                r_opx    <= r_px;
                r_opy    <= r_py;
            end else if (o_pose.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_tick.valid) begin
                        r_lring[r_rslot] <= i_tick.left_ticks;
                        r_rring[r_rslot] <= i_tick.right_ticks;
                        r_rslot <= (r_rslot == RS_BITS'(AVG_TAPS - 1)) ? '0
                                 : r_rslot + 1'b1;
                        r_lsum  <= '0;
                        r_rsum  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SUM;
                    end
                end
                // ring sum, one tap per cycle
                S_SUM: begin
                    r_lsum <= r_lsum + SUM_BITS'(r_lring[r_cnt[RS_BITS-1:0]]);
                    r_rsum <= r_rsum + SUM_BITS'(r_rring[r_cnt[RS_BITS-1:0]]);
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_BITS'(AVG_TAPS - 1)) r_state <= S_MULL;
                end
                S_MULL: begin
                    r_vl <= spd_sat;
                    r_state <= S_MULR;
                end
                S_MULR: begin
                    r_vr <= spd_sat;
                    r_lgrp[r_gslot[GI_BITS-1:0]] <= r_vl;
                    r_rgrp[r_gslot[GI_BITS-1:0]] <= spd_sat;
                    r_glsum <= '0;
                    r_grsum <= '0;
                    r_cnt   <= '0;
                    if (r_gslot == GS_BITS'(POSE_GROUP - 1)) begin
                        r_gslot <= '0;
                        r_state <= S_GSUM;
                    end else begin
                        r_gslot <= r_gslot + 1'b1;
                        r_upd   <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                // group sum, one entry per cycle
                S_GSUM: begin
                    r_glsum <= r_glsum + GSUM_BITS'(r_lgrp[r_cnt[GI_BITS-1:0]]);
                    r_grsum <= r_grsum + GSUM_BITS'(r_rgrp[r_cnt[GI_BITS-1:0]]);
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == CNT_BITS'(POSE_GROUP - 1)) r_state <= S_AVGL;
                end
                // group averages by reciprocal multiplication
                S_AVGL: begin
                    r_al    <= SPEED_BITS'(mul_p >>> AVG_SH);
                    r_state <= S_AVGR;
                end
                S_AVGR: begin
                    r_ar    <= SPEED_BITS'(mul_p >>> AVG_SH);
                    r_state <= S_HEAD;
                end
                S_HEAD: begin
                    r_h <= 20'(r_head) + h_add;
                    r_state <= S_WRAP;
                end
                // single wrap then clamp
                S_WRAP: begin
                    logic signed [19:0] h;
                    h = r_h;
                    if (h > PI_Q13) h = h - TWO_PI_Q13;
                    else if (h < -PI_Q13) h = h + TWO_PI_Q13;
                    if (h > PI_Q13) h = PI_Q13;
                    if (h < -PI_Q13) h = -PI_Q13;
                    r_head   <= h[HEAD_BITS-1:0];
                    r_state  <= S_CORD;
                end
                S_CORD: begin
                    if (cr.done) r_state <= S_PX;
                end
                S_PX: begin
                    r_px <= pos_sat;
                    r_state <= S_PY;
                end
                S_PY: begin
                    r_py <= pos_sat;
                    r_upd <= 1'b1;
                    r_state <= S_OUT;
                end
                // wait for a free output register
                S_OUT: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_pose.valid        = r_ovalid;
    assign o_pose.left_speed   = r_ovl;
    assign o_pose.right_speed  = r_ovr;
    assign o_pose.pose_updated = r_oupd;
    assign o_pose.heading      = r_ohead;
    assign o_pose.pos_x        = r_opx;
    assign o_pose.pos_y        = r_opy;

endmodule

// ===== design/wodr_cordic.sv =====
// ----------------------------------------------------------------------------
// wodr_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module wodr_cordic
    import wodr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_req i_req,
    output t_cordic_rsp o_rsp
);

    logic signed [33:0] r_x, r_y;
    logic signed [20:0] r_z;
    logic [3:0]         r_iter;
    logic               r_busy, r_neg, r_done;

    logic signed [20:0] n_z0;
    logic               n_neg0;
    logic signed [33:0] sx, sy;

    // quadrant fold of the start angle
    always_comb begin
        n_z0   = 21'(i_req.angle) * 21'sd8;
        n_neg0 = 1'b0;
        if (n_z0 > 21'(HALF_PI_Q16)) begin
            n_z0   = n_z0 - 21'(PI_Q16);
            n_neg0 = 1'b1;
        end else if (n_z0 < -21'(HALF_PI_Q16)) begin
            n_z0   = n_z0 + 21'(PI_Q16);
            n_neg0 = 1'b1;
        end
    end

    assign sx = r_x >>> r_iter;
    assign sy = r_y >>> r_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= n_z0;
                r_neg  <= n_neg0;
            end else if (r_busy) begin
                if (!r_z[20]) begin
                    r_x <= r_x - sy;
                    r_y <= r_y + sx;
                    r_z <= r_z - 21'(ATAN_Q16[r_iter]);
                end else begin
                    r_x <= r_x + sy;
                    r_y <= r_y - sx;
                    r_z <= r_z + 21'(ATAN_Q16[r_iter]);
                end
                r_iter <= r_iter + 4'd1;
                if (r_iter == 4'(CORDIC_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.cos_v = r_neg ? -r_x : r_x;
    assign o_rsp.sin_v = r_neg ? -r_y : r_y;

endmodule

// ===== dv/tb_wodr_if.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wodr_if
// testbench copy point for channel interfaces (interfaces come from design)
// ----------------------------------------------------------------------------
package tb_wodr_types;
    typedef struct {
        logic [11:0]        left_speed;
        logic [11:0]        right_speed;
        logic               pose_updated;
        logic signed [15:0] heading;
        logic signed [27:0] pos_x;
        logic signed [27:0] pos_y;
    } t_pose_result;
endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the odometry core against a bit-true pose predictor under random
// input bursts, output stalls, a long output hold-off and gain changes
// ----------------------------------------------------------------------------
import wodr_pkg::*;
import tb_wodr_types::*;

class pose_scoreboard;
    int unsigned  lgain, rgain;
    int unsigned  lring [3], rring [3], lgrp [5], rgrp [5];
    int unsigned  rslot, gslot;
    longint       head, px, py;
    t_pose_result pending [$];
    int           errors;

    function void clear();
        lgain = LEFT_GAIN_RST; rgain = RIGHT_GAIN_RST;
        foreach (lring[i]) begin lring[i] = 0; rring[i] = 0; end
        foreach (lgrp[i]) begin lgrp[i] = 0; rgrp[i] = 0; end
        rslot = 0; gslot = 0; head = 0; px = 0; py = 0; errors = 0;
    endfunction

    function void set_gain(int idx, int unsigned val);
        if (idx == CFG_LEFT_GAIN) lgain = val & 16'hffff;
        else if (idx == CFG_RIGHT_GAIN) rgain = val & 16'hffff;
    endfunction

    static function longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    static function int unsigned speed_of(int unsigned r [3], int unsigned g);
        longint unsigned sum;
        sum = ((longint'(r[0]) + r[1] + r[2]) * g) >> 16;
        return (sum > 4095) ? 4095 : int'(sum);
    endfunction

    static function longint sat28(longint v);
        if (v > 134217727) return 134217727;
        if (v < -134217728) return -134217728;
        return v;
    endfunction

    // 16-step rotation of the start gain vector
    static function void rotate(longint h, output longint c, output longint s);
        longint z, x, y, nx;
        bit     flip;
        z = h * 8; x = 652032874; y = 0; flip = 0;
        if (z > 102944) begin z -= 205887; flip = 1; end
        else if (z < -102944) begin z += 205887; flip = 1; end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - fshift(y, i); y = y + fshift(x, i); z -= ATAN_Q16[i];
            end else begin
                nx = x + fshift(y, i); y = y - fshift(x, i); z += ATAN_Q16[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // accepted request: advance state and queue the expected result
    function void note_sample(logic [11:0] lt, logic [11:0] rt);
        t_pose_result r;
        int unsigned  vl, vr, sl, sr;
        longint       al, ar, h, trip_len, c, s;
        lring[rslot] = lt; rring[rslot] = rt;
        rslot = (rslot + 1) % 3;
        vl = speed_of(lring, lgain);
        vr = speed_of(rring, rgain);
        lgrp[gslot] = vl; rgrp[gslot] = vr;
        gslot++;
        r.pose_updated = 0;
        if (gslot == 5) begin
            sl = 0; sr = 0;
            for (int i = 0; i < 5; i++) begin sl += lgrp[i]; sr += rgrp[i]; end
            al = sl / 5; ar = sr / 5;
            h = head + (((ar - al) * 2360910 + 32768) >>> 16);
            if (h > 25736) h -= 51472;
            else if (h < -25736) h += 51472;
            if (h > 25736) h = 25736;
            if (h < -25736) h = -25736;
            head = h;
            trip_len = (ar + al) * 32;
            rotate(head, c, s);
            px = sat28(px + ((trip_len * c + (64'sd1 << 29)) >>> 30));
            py = sat28(py + ((trip_len * s + (64'sd1 << 29)) >>> 30));
            gslot = 0;
            r.pose_updated = 1;
        end
        r.left_speed = vl[11:0]; r.right_speed = vr[11:0];
        r.heading = head[15:0]; r.pos_x = px[27:0]; r.pos_y = py[27:0];
        pending.push_back(r);
    endfunction

    function void check_result(t_pose_result got);
        t_pose_result e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.left_speed !== e.left_speed || got.right_speed !== e.right_speed ||
            got.pose_updated !== e.pose_updated || got.heading !== e.heading ||
            got.pos_x !== e.pos_x || got.pos_y !== e.pos_y) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, got);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic i_clk = 0;
    logic i_rst_n = 0;
    wodr_tick_if tick_ch ();
    wodr_pose_if pose_ch ();
    wodr_cfg_if  cfg_ch ();

    pose_scoreboard sb;
    int  cycle_cnt = 0;
    int  hold_cycles = 0;
    bit  stall_pattern = 0;

    always #4 i_clk = ~i_clk;

    wheel_odometry_dead_reckoning_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_ch.sink),
        .o_pose  (pose_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // monitor: check every accepted result, note every accepted request and gain write
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (tick_ch.valid && tick_ch.ready)
                sb.note_sample(tick_ch.left_ticks, tick_ch.right_ticks);
            if (pose_ch.valid && pose_ch.ready) begin
                t_pose_result got;
                got.left_speed = pose_ch.left_speed;
                got.right_speed = pose_ch.right_speed;
                got.pose_updated = pose_ch.pose_updated;
                got.heading = pose_ch.heading;
                got.pos_x = pose_ch.pos_x;
                got.pos_y = pose_ch.pos_y;
                sb.check_result(got);
            end
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_gain(cfg_ch.index, cfg_ch.data);
        end
    end

    // receiver stalls: random pattern, one long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            pose_ch.ready <= 0;
        end else if (stall_pattern)
            pose_ch.ready <= ($urandom_range(0, 3) != 0);
        else
            pose_ch.ready <= 1;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 400000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_sample(logic [11:0] lt, logic [11:0] rt);
        tick_ch.valid <= 1;
        tick_ch.left_ticks <= lt;
        tick_ch.right_ticks <= rt;
        do @(posedge i_clk); while (!tick_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic pause_sender();
        tick_ch.valid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    task automatic write_gain(logic [7:0] idx, logic [15:0] val);
        cfg_ch.valid <= 1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 0;
    endtask

    task automatic drain();
        tick_ch.valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic random_burst(int n, bit wide);
        int left;
        left = n;
        while (left > 0) begin
            int blen;
            blen = $urandom_range(1, 20);
            if (blen > left) blen = left;
            repeat (blen) begin
                if (wide || $urandom_range(0, 9) == 0)
                    send_sample(12'($urandom_range(0, 4095)),
                                12'($urandom_range(0, 4095)));
                else
                    send_sample(12'($urandom_range(0, 300)),
                                12'($urandom_range(0, 300)));
            end
            left -= blen;
            if ($urandom_range(0, 2) != 0) pause_sender();
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        tick_ch.valid = 0; tick_ch.left_ticks = 0; tick_ch.right_ticks = 0;
        pose_ch.ready = 0;
        cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
        i_rst_n = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;

        // directed: extremes, saturation, large turns both ways
        send_sample(0, 0);
        send_sample(12'hfff, 12'hfff);
        send_sample(12'hfff, 0);
        send_sample(0, 12'hfff);
        send_sample(12'haaa, 12'h555);
        repeat (10) send_sample(0, 4095);
        repeat (10) send_sample(4095, 0);
        drain();
        write_gain(CFG_LEFT_GAIN, 16'hffff);
        write_gain(CFG_RIGHT_GAIN, 16'h0000);
        write_gain(8'd7, 16'h1234);
        repeat (10) send_sample(4095, 4095);
        drain();

        // random phases over several gain settings
        stall_pattern = 1;
        for (int ph = 0; ph < 6; ph++) begin
            write_gain(CFG_LEFT_GAIN, (ph == 0) ? 16'h0000 :
                       (ph == 1) ? 16'hffff : 16'($urandom));
            write_gain(CFG_RIGHT_GAIN, (ph == 0) ? 16'hffff :
                       (ph == 1) ? 16'h0001 : 16'($urandom));
            if (ph == 2) hold_cycles = 400;
            stall_pattern = (ph % 3 != 1);
            random_burst(150, ph == 1);
            drain();
        end

        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
